@@ design/psa_pkg.sv @@
// Package for the priority scan arbiter: transfer payload types and fixed constants.
// No dependencies; every other design file refers to it by scoped names.
`timescale 1ns / 1ps

package psa_pkg;

	localparam int SLOT_W     = 6;
	localparam int PRIO_W     = 7;
	localparam int TICK_W     = 16;
	localparam int TIMES_W    = 16;
	localparam int CREATED_W  = 32;
	localparam int NICE_W     = 4;
	localparam int QUOT_STEPS = 4;
	localparam int STEP_W     = 2;
	localparam int DIVISOR_W  = TICK_W + 1;
	localparam int REM_W      = TICK_W + 4;

	localparam logic [PRIO_W-1:0] PRIO_MAX  = 7'd100;
	localparam logic [PRIO_W:0]   PRIO_BIAS = 8'd5;

	typedef struct packed {
		logic                 runnable;
		logic [PRIO_W-1:0]    static_priority;
		logic [TICK_W-1:0]    sleep_ticks;
		logic [TICK_W-1:0]    run_ticks;
		logic [TIMES_W-1:0]   times_scheduled;
		logic [CREATED_W-1:0] created_at;
		logic                 last_entry;
	} item_t;

	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] winner_slot;
		logic [PRIO_W-1:0] winner_priority;
	} result_t;

	typedef struct packed {
		logic              load;
		logic              step;
		logic [STEP_W-1:0] step_idx;
		logic              update;
		logic              emit;
	} cmd_t;

	typedef struct packed {
		logic last;
	} status_t;

endpackage

@@ design/priority_scan_arbiter_core.sv @@
// Top level of the priority scan arbiter: joins controller and datapath.
// Depends on psa_pkg, psa_ctrl and psa_dp.
//
//   channel | direction | handshake              | payload
//   item    | in        | item_valid/item_stall  | psa_pkg::item_t
//   result  | out       | result_valid/result_stall | psa_pkg::result_t
//
// An entry runs four restoring divide steps and then one update step; a further entry
// can be taken in that update step unless the current one is the last.
// A last entry loads the result register in the emit state, held while stalled.
// arst_n clears the scan position, the best-entry flag and the output valid.
// A new entry is taken while a result waits for its transfer.
`timescale 1ns / 1ps

module priority_scan_arbiter_core #(
	parameter int MAX_SLOTS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  psa_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output psa_pkg::result_t result
);

	psa_pkg::cmd_t    cmd;
	psa_pkg::status_t status;

	psa_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.cmd          (cmd)
	);

	psa_dp #(
		.MAX_SLOTS (MAX_SLOTS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.item   (item),
		.status (status),
		.result (result)
	);

endmodule

@@ design/psa_dp.sv @@
// Datapath of the priority scan arbiter: entry registers, four-step niceness divider,
// dynamic priority, best-entry tracking and the result register. Depends on psa_pkg.
`timescale 1ns / 1ps

module psa_dp #(
	parameter int MAX_SLOTS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  psa_pkg::cmd_t    cmd,
	input  psa_pkg::item_t   item,
	output psa_pkg::status_t status,
	output psa_pkg::result_t result
);

	localparam int POS_W = $clog2(MAX_SLOTS + 1);
	localparam int EXT_W = POS_W + psa_pkg::SLOT_W;

	logic [POS_W-1:0]                pos_q;
	logic                            have_best_q;
	logic [psa_pkg::SLOT_W-1:0]      best_slot_q;
	logic [psa_pkg::PRIO_W-1:0]      best_prio_q;
	logic [psa_pkg::TIMES_W-1:0]     best_times_q;
	logic [psa_pkg::CREATED_W-1:0]   best_created_q;

	logic                            runnable_q;
	logic                            last_q;
	logic                            zero_q;
	logic [psa_pkg::PRIO_W-1:0]      sp_q;
	logic [psa_pkg::TIMES_W-1:0]     times_q;
	logic [psa_pkg::CREATED_W-1:0]   created_q;
	logic [psa_pkg::REM_W-1:0]       rem_q;
	logic [psa_pkg::DIVISOR_W-1:0]   div_q;
	logic [psa_pkg::NICE_W-1:0]      quot_q;
	psa_pkg::result_t                result_q;

	logic [psa_pkg::REM_W-1:0]       sleep_ext;
	logic [psa_pkg::REM_W-1:0]       sleep_x10;
	logic [psa_pkg::REM_W:0]         div_sh;
	logic                            sub_ok;
	logic [psa_pkg::PRIO_W-1:0]      sp_c;
	logic [psa_pkg::PRIO_W:0]        raw;
	logic [psa_pkg::PRIO_W:0]        nice;
	logic [psa_pkg::PRIO_W:0]        diff;
	logic [psa_pkg::PRIO_W-1:0]      dyn_prio;
	logic                            eligible;
	logic                            take;
	logic                            at_end;
	logic [EXT_W-1:0]                pos_ext;

	assign sleep_ext = psa_pkg::REM_W'(item.sleep_ticks);
	assign sleep_x10 = (sleep_ext << 3) + (sleep_ext << 1);
	assign div_sh    = (psa_pkg::REM_W+1)'(div_q) << cmd.step_idx;
	assign sub_ok    = ({1'b0, rem_q} >= div_sh);

	assign sp_c = (sp_q > psa_pkg::PRIO_MAX) ? psa_pkg::PRIO_MAX : sp_q;
	assign raw  = {1'b0, sp_c} + psa_pkg::PRIO_BIAS;
	assign nice = (psa_pkg::PRIO_W+1)'(quot_q);
	assign diff = raw - nice;

	always_comb begin
		priority if (zero_q) begin
			dyn_prio = sp_c;
		end else if (raw <= nice) begin
			dyn_prio = '0;
		end else if (diff > {1'b0, psa_pkg::PRIO_MAX}) begin
			dyn_prio = psa_pkg::PRIO_MAX;
		end else begin
			dyn_prio = diff[psa_pkg::PRIO_W-1:0];
		end
	end

	assign at_end   = (pos_q >= POS_W'(MAX_SLOTS));
	assign eligible = runnable_q && !at_end;
	assign pos_ext  = EXT_W'(pos_q);

	always_comb begin
		priority if (!have_best_q) begin
			take = 1'b1;
		end else if (dyn_prio != best_prio_q) begin
			take = dyn_prio < best_prio_q;
		end else if (times_q != best_times_q) begin
			take = times_q < best_times_q;
		end else begin
			take = created_q < best_created_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			have_best_q <= 1'b0;
		end else if (cmd.emit) begin
			pos_q       <= '0;
			have_best_q <= 1'b0;
		end else if (cmd.update) begin
			if (eligible && take) begin
				have_best_q <= 1'b1;
			end
			if (!at_end) begin
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			runnable_q <= item.runnable;
			last_q     <= item.last_entry;
			sp_q       <= item.static_priority;
			times_q    <= item.times_scheduled;
			created_q  <= item.created_at;
			zero_q     <= (item.sleep_ticks == '0) && (item.run_ticks == '0);
			rem_q      <= sleep_x10;
			div_q      <= psa_pkg::DIVISOR_W'(item.sleep_ticks)
				+ psa_pkg::DIVISOR_W'(item.run_ticks);
			quot_q     <= '0;
		end else if (cmd.step) begin
			if (sub_ok) begin
				rem_q                <= rem_q - div_sh[psa_pkg::REM_W-1:0];
				quot_q[cmd.step_idx] <= 1'b1;
			end
		end
		if (cmd.update && eligible && take) begin
			best_slot_q    <= pos_ext[psa_pkg::SLOT_W-1:0];
			best_prio_q    <= dyn_prio;
			best_times_q   <= times_q;
			best_created_q <= created_q;
		end
		if (cmd.emit) begin
			if (have_best_q) begin
				result_q.found           <= 1'b1;
				result_q.winner_slot     <= best_slot_q;
				result_q.winner_priority <= best_prio_q;
			end else begin
				result_q <= '0;
			end
		end
	end

	assign status.last = last_q;
	assign result      = result_q;

endmodule

@@ design/psa_ctrl.sv @@
// Controller of the priority scan arbiter: sequencing state machine, transfer handshakes
// and datapath commands. Depends on psa_pkg.
`timescale 1ns / 1ps

module psa_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	output logic             result_valid,
	input  logic             result_stall,
	input  psa_pkg::status_t status,
	output psa_pkg::cmd_t    cmd
);

	typedef enum logic [1:0] {
		IDLE,
		DIV,
		UPD,
		EMIT
	} state_t;

	state_t                     state_q;
	logic [psa_pkg::STEP_W-1:0] step_q;
	logic                       result_valid_q;
	logic                       accept;
	logic                       out_free;

	assign out_free   = !result_valid_q || !result_stall;
	assign item_stall = !((state_q == IDLE) || ((state_q == UPD) && !status.last));
	assign accept     = item_valid && !item_stall;

	assign cmd.load     = accept;
	assign cmd.step     = (state_q == DIV);
	assign cmd.step_idx = step_q;
	assign cmd.update   = (state_q == UPD);
	assign cmd.emit     = (state_q == EMIT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= IDLE;
			step_q         <= '0;
			result_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (accept) begin
						state_q <= DIV;
						step_q  <= psa_pkg::STEP_W'(psa_pkg::QUOT_STEPS - 1);
					end
				end
				DIV: begin
					if (step_q == '0) begin
						state_q <= UPD;
					end else begin
						step_q <= step_q - psa_pkg::STEP_W'(1);
					end
				end
				UPD: begin
					priority if (status.last) begin
						state_q <= EMIT;
					end else if (accept) begin
						state_q <= DIV;
						step_q  <= psa_pkg::STEP_W'(psa_pkg::QUOT_STEPS - 1);
					end else begin
						state_q <= IDLE;
					end
				end
				EMIT: begin
					if (out_free) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
			if (cmd.emit) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = result_valid_q;

`ifndef SYNTHESIS
	a_accept_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == DIV)
			&& (step_q == psa_pkg::STEP_W'(psa_pkg::QUOT_STEPS - 1)))
		else $error("accepted transfer did not start the divider");
	a_div_ends_in_upd: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == DIV) && (step_q == '0)) |=> (state_q == UPD))
		else $error("divider did not hand over to update");
	a_emit_waits: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == EMIT) && !out_free) |=> ((state_q == EMIT) && result_valid_q))
		else $error("result overwritten while output held");
`endif

endmodule
